@@ hdl/ile_pkg.sv @@
// ----------------------------------------------------------------------------
// ile_pkg: shared constants for the indexed list engine
// Action codes, outcome codes, default sizes and controller commands.
// ----------------------------------------------------------------------------
package ile_pkg;

   localparam int DepthDefault     = 64;
   localparam int WordWidthDefault = 32;
   localparam int ActionWidth      = 4;
   localparam int IndexWidth       = 7;
   localparam int OperandWidth     = 32;
   localparam int OutcomeWidth     = 2;
   localparam int CountWidth       = 7;

   localparam logic [ActionWidth-1:0] ACT_APPEND    = 4'd0;
   localparam logic [ActionWidth-1:0] ACT_CLEAR     = 4'd1;
   localparam logic [ActionWidth-1:0] ACT_SET       = 4'd2;
   localparam logic [ActionWidth-1:0] ACT_GET       = 4'd3;
   localparam logic [ActionWidth-1:0] ACT_REMOVE    = 4'd4;
   localparam logic [ActionWidth-1:0] ACT_MOVE      = 4'd5;
   localparam logic [ActionWidth-1:0] ACT_DUPLICATE = 4'd6;
   localparam logic [ActionWidth-1:0] ACT_NEGATE    = 4'd7;
   localparam logic [ActionWidth-1:0] ACT_TEST      = 4'd8;
   localparam logic [ActionWidth-1:0] ACT_PRINT     = 4'd9;

   localparam logic [OutcomeWidth-1:0] OUT_OK    = 2'd0;
   localparam logic [OutcomeWidth-1:0] OUT_RANGE = 2'd1;
   localparam logic [OutcomeWidth-1:0] OUT_FULL  = 2'd2;

   // controller -> datapath commands
   typedef struct packed {
      logic load;        // capture request fields
      logic rd_en;       // RAM read at rd_addr
      logic [1:0] rd_sel;// 0 pos,1 walk,2 walk+1,3 walk-1
      logic wr_en;       // RAM write
      logic [2:0] wr_sel;// 0 operand,1 rdata,2 neg rdata,3 held value
      logic [1:0] wa_sel;// 0 pos,1 count,2 walk,3 dst
      logic walk_pos;    // walk <- pos
      logic walk_cnt;    // walk <- count
      logic walk_dst;    // walk <- dst
      logic walk_zero;   // walk <- 0
      logic walk_inc;
      logic walk_dec;
      logic hold_rdata;  // held <- rdata
      logic cnt_inc;
      logic cnt_dec;
      logic cnt_clr;
      logic dst_clip;    // dst <- min(dst,count)
      logic rsp;         // emit response
      logic rsp_val;     // response carries rdata
      logic rsp_eq;      // response is equality test
      logic [1:0] rsp_oc;
      logic rsp_last;
   } ile_cmd_type;

   typedef struct packed {
      logic [3:0] action;
      logic pos_ok;
      logic dst_ok;
      logic full;
      logic empty;
      logic walk_gt_pos;  // walk > pos
      logic walk_gt_dst;  // walk > dst
      logic walk_lt_end;  // walk+1 < count
      logic walk_last;    // walk+1 == count
   } ile_sts_type;

endpackage

@@ hdl/ile_ram.sv @@
// ----------------------------------------------------------------------------
// ile_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ile_ram #(
   parameter int Width = 32,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

@@ hdl/ile_datapath.sv @@
// ----------------------------------------------------------------------------
// ile_datapath: list storage, count, walk pointer and response register
// Executes controller commands one RAM access each way per cycle.
// ----------------------------------------------------------------------------
module ile_datapath #(
   parameter int Depth     = ile_pkg::DepthDefault,
   parameter int WordWidth = ile_pkg::WordWidthDefault
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ile_pkg::ile_cmd_type                cmd,
   output ile_pkg::ile_sts_type                sts,
   input  logic [ile_pkg::ActionWidth-1:0]     req_action,
   input  logic [ile_pkg::IndexWidth-1:0]      req_position,
   input  logic [ile_pkg::IndexWidth-1:0]      req_destination,
   input  logic signed [ile_pkg::OperandWidth-1:0] req_operand,
   output logic signed [ile_pkg::OperandWidth-1:0] rsp_read_value,
   output logic                                rsp_has_value,
   output logic                                rsp_equal_hit,
   output logic [ile_pkg::OutcomeWidth-1:0]    rsp_outcome,
   output logic [ile_pkg::CountWidth-1:0]      rsp_entry_count,
   output logic                                rsp_last_of_run,
   output logic                                rsp_strobe
);
   import ile_pkg::*;

   localparam int AW = $clog2(Depth);
   localparam int CW = $clog2(Depth + 1);
   localparam int IW = (IndexWidth > CW) ? IndexWidth : CW;

   logic [ActionWidth-1:0] action_ff;
   logic [IW-1:0] pos_ff, dst_ff, walk_ff;
   logic [WordWidth-1:0] opnd_ff, held_ff, rdata, wdata;
   logic [CW-1:0] count_ff;
   logic [IW-1:0] count_x, walk_p1, rd_idx, wa_idx;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [OperandWidth-1:0] rvalue_ext;

   assign count_x = IW'(count_ff);
   assign walk_p1 = walk_ff + IW'(1);

   // request capture and walk pointer
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= req_action;
         pos_ff    <= IW'(req_position);
         dst_ff    <= IW'(req_destination);
         opnd_ff   <= WordWidth'(req_operand);
      end
      if (cmd.dst_clip && dst_ff > count_x) begin
         dst_ff <= count_x;
      end
      if (cmd.hold_rdata) begin
         held_ff <= rdata;
      end
      if (cmd.walk_pos) begin
         walk_ff <= pos_ff;
      end else if (cmd.walk_cnt) begin
         walk_ff <= count_x;
      end else if (cmd.walk_dst) begin
         walk_ff <= dst_ff;
      end else if (cmd.walk_zero) begin
         walk_ff <= '0;
      end else if (cmd.walk_inc) begin
         walk_ff <= walk_p1;
      end else if (cmd.walk_dec) begin
         walk_ff <= walk_ff - IW'(1);
      end
   end

   // entry count
   always_ff @(posedge clock) begin
      if (reset || cmd.cnt_clr) begin
         count_ff <= '0;
      end else if (cmd.cnt_inc) begin
         count_ff <= count_ff + CW'(1);
      end else if (cmd.cnt_dec) begin
         count_ff <= count_ff - CW'(1);
      end
   end

   // address and write data selection
   always_comb begin
      case (cmd.rd_sel)
         2'd0:    rd_idx = pos_ff;
         2'd1:    rd_idx = walk_ff;
         2'd2:    rd_idx = walk_p1;
         default: rd_idx = walk_ff - IW'(1);
      endcase
      case (cmd.wa_sel)
         2'd0:    wa_idx = pos_ff;
         2'd1:    wa_idx = count_x;
         2'd2:    wa_idx = walk_ff;
         default: wa_idx = dst_ff;
      endcase
      case (cmd.wr_sel)
         3'd0:    wdata = opnd_ff;
         3'd1:    wdata = rdata;
         3'd2:    wdata = WordWidth'(0) - rdata;
         default: wdata = held_ff;
      endcase
   end
   assign rd_addr = rd_idx[AW-1:0];
   assign wr_addr = wa_idx[AW-1:0];

   ile_ram #(.Width(WordWidth), .Depth(Depth)) u_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wdata),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rdata)
   );

   // status toward the controller
   always_comb begin
      sts.action      = action_ff;
      sts.pos_ok      = pos_ff < count_x;
      sts.dst_ok      = dst_ff <= count_x;
      sts.full        = count_ff >= CW'(Depth);
      sts.empty       = count_ff == '0;
      sts.walk_gt_pos = walk_ff > pos_ff;
      sts.walk_gt_dst = walk_ff > dst_ff;
      sts.walk_lt_end = walk_p1 < count_x;
      sts.walk_last   = walk_p1 == count_x;
   end

   // sign-extend or truncate stored word to the port width
   always_comb begin
      if (OperandWidth > WordWidth) begin
         rvalue_ext = OperandWidth'($signed(rdata));
      end else begin
         rvalue_ext = rdata[OperandWidth-1:0];
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= cmd.rsp;
      end
      if (cmd.rsp) begin
         rsp_read_value  <= cmd.rsp_val ? rvalue_ext : '0;
         rsp_has_value   <= cmd.rsp_val;
         rsp_equal_hit   <= cmd.rsp_eq && sts.pos_ok && (rdata == opnd_ff);
         rsp_outcome     <= cmd.rsp_oc;
         rsp_last_of_run <= cmd.rsp_last;
         if (cmd.cnt_inc) begin
            rsp_entry_count <= CountWidth'(count_ff + CW'(1));
         end else if (cmd.cnt_dec) begin
            rsp_entry_count <= CountWidth'(count_ff - CW'(1));
         end else if (cmd.cnt_clr) begin
            rsp_entry_count <= '0;
         end else begin
            rsp_entry_count <= CountWidth'(count_ff);
         end
      end
   end
endmodule

@@ hdl/ile_control.sv @@
// ----------------------------------------------------------------------------
// ile_control: sequencer for list actions
// Decodes the captured action and steps the datapath through shifts and runs.
// ----------------------------------------------------------------------------
module ile_control (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output ile_pkg::ile_cmd_type  cmd,
   input  ile_pkg::ile_sts_type  sts
);
   import ile_pkg::*;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_DEC    = 4'd1;
   localparam logic [3:0] ST_RD     = 4'd2;  // read at pos issued
   localparam logic [3:0] ST_DN_RD  = 4'd3;  // close gap: read walk+1
   localparam logic [3:0] ST_DN_WR  = 4'd4;  // write walk
   localparam logic [3:0] ST_UP_RD  = 4'd5;  // open gap: read walk-1
   localparam logic [3:0] ST_UP_WR  = 4'd6;
   localparam logic [3:0] ST_PR_RD  = 4'd7;
   localparam logic [3:0] ST_PR_OUT = 4'd8;
   localparam logic [3:0] ST_MV_PUT = 4'd9;

   logic [3:0] state_ff, state_in;
   logic moving_ff, moving_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         moving_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         moving_ff <= moving_in;
      end
   end

   assign busy = state_ff != ST_IDLE;

   always_comb begin
      state_in  = state_ff;
      moving_in = moving_ff;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DEC;
            end
         end
         ST_DEC: begin
            state_in = ST_IDLE;
            cmd.rsp  = 1'b1;
            cmd.rsp_last = 1'b1;
            case (sts.action)
               ACT_APPEND: begin
                  if (sts.full) begin
                     cmd.rsp_oc = OUT_FULL;
                  end else begin
                     cmd.wr_en = 1'b1; cmd.wa_sel = 2'd1; cmd.cnt_inc = 1'b1;
                  end
               end
               ACT_CLEAR: cmd.cnt_clr = 1'b1;
               ACT_SET: begin
                  if (!sts.pos_ok) begin
                     cmd.rsp_oc = OUT_RANGE;
                  end else begin
                     cmd.wr_en = 1'b1;
                  end
               end
               ACT_GET, ACT_NEGATE, ACT_TEST: begin
                  if (!sts.pos_ok && sts.action != ACT_TEST) begin
                     cmd.rsp_oc = OUT_RANGE;
                  end else begin
                     cmd.rsp = 1'b0; cmd.rd_en = 1'b1; state_in = ST_RD;
                  end
               end
               ACT_REMOVE, ACT_MOVE: begin
                  if (!sts.pos_ok || (sts.action == ACT_MOVE && !sts.dst_ok)) begin
                     cmd.rsp_oc = OUT_RANGE;
                  end else begin
                     cmd.rsp = 1'b0; cmd.rd_en = 1'b1; cmd.walk_pos = 1'b1;
                     moving_in = sts.action == ACT_MOVE;
                     state_in = ST_RD;
                  end
               end
               ACT_DUPLICATE: begin
                  if (!sts.pos_ok) begin
                     cmd.rsp_oc = OUT_RANGE;
                  end else if (sts.full) begin
                     cmd.rsp_oc = OUT_FULL;
                  end else begin
                     cmd.rsp = 1'b0; cmd.walk_cnt = 1'b1; moving_in = 1'b0;
                     state_in = ST_UP_RD;
                  end
               end
               ACT_PRINT: begin
                  if (!sts.empty) begin
                     cmd.rsp = 1'b0; cmd.walk_zero = 1'b1; state_in = ST_PR_RD;
                  end
               end
               default: ;
            endcase
         end
         ST_RD: begin
            // read data at pos is valid now
            case (sts.action)
               ACT_GET: begin
                  cmd.rsp = 1'b1; cmd.rsp_val = 1'b1; cmd.rsp_last = 1'b1;
                  state_in = ST_IDLE;
               end
               ACT_TEST: begin
                  cmd.rsp = 1'b1; cmd.rsp_eq = 1'b1; cmd.rsp_last = 1'b1;
                  state_in = ST_IDLE;
               end
               ACT_NEGATE: begin
                  cmd.wr_en = 1'b1; cmd.wr_sel = 3'd2;
                  cmd.rsp = 1'b1; cmd.rsp_last = 1'b1;
                  state_in = ST_IDLE;
               end
               default: begin
                  // remove / move: keep value, then close gap
                  cmd.hold_rdata = 1'b1;
                  state_in = ST_DN_RD;
               end
            endcase
         end
         ST_DN_RD: begin
            if (sts.walk_lt_end) begin
               cmd.rd_en = 1'b1; cmd.rd_sel = 2'd2; state_in = ST_DN_WR;
            end else begin
               cmd.cnt_dec = 1'b1;
               if (moving_ff) begin
                  state_in = ST_MV_PUT;
               end else begin
                  cmd.rsp = 1'b1; cmd.rsp_last = 1'b1; state_in = ST_IDLE;
               end
            end
         end
         ST_DN_WR: begin
            cmd.wr_en = 1'b1; cmd.wr_sel = 3'd1; cmd.wa_sel = 2'd2;
            cmd.walk_inc = 1'b1; state_in = ST_DN_RD;
         end
         ST_MV_PUT: begin
            // clip destination, then open gap from count down to it
            cmd.dst_clip = 1'b1; cmd.walk_cnt = 1'b1;
            state_in = ST_UP_RD;
         end
         ST_UP_RD: begin
            if ((moving_ff && sts.walk_gt_dst) || (!moving_ff && sts.walk_gt_pos)) begin
               cmd.rd_en = 1'b1; cmd.rd_sel = 2'd3; state_in = ST_UP_WR;
            end else begin
               cmd.cnt_inc = 1'b1; cmd.rsp = 1'b1; cmd.rsp_last = 1'b1;
               if (moving_ff) begin
                  cmd.wr_en = 1'b1; cmd.wr_sel = 3'd3; cmd.wa_sel = 2'd3;
               end
               state_in = ST_IDLE;
            end
         end
         ST_UP_WR: begin
            cmd.wr_en = 1'b1; cmd.wr_sel = 3'd1; cmd.wa_sel = 2'd2;
            cmd.walk_dec = 1'b1; state_in = ST_UP_RD;
         end
         ST_PR_RD: begin
            cmd.rd_en = 1'b1; cmd.rd_sel = 2'd1; state_in = ST_PR_OUT;
         end
         ST_PR_OUT: begin
            cmd.rsp = 1'b1; cmd.rsp_val = 1'b1;
            if (sts.walk_last) begin
               cmd.rsp_last = 1'b1; state_in = ST_IDLE;
            end else begin
               cmd.walk_inc = 1'b1; state_in = ST_PR_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

@@ hdl/indexed_list_engine.sv @@
// ----------------------------------------------------------------------------
// indexed_list_engine: ordered list of signed words with indexed actions
// Append, clear, set, get, remove, move, duplicate, negate, test and print.
// ----------------------------------------------------------------------------
// Channel   Handshake        Ports
// request   start / busy     req_action req_position req_destination req_operand
// response  rsp_strobe only  rsp_read_value rsp_has_value rsp_equal_hit
//                            rsp_outcome rsp_entry_count rsp_last_of_run
//
// Append, clear, set and errors finish in the decode step; get, test and
// negate add a RAM read. Remove shifts the entries after pos down; move then
// shifts entries from the end up to dst, with dst first clipped to count-1;
// duplicate shifts entries from pos to the end up: one RAM read and one
// write per shifted entry. Print emits one response per entry, in order.
// Synchronous reset clears the count; list contents stay undefined.
// Responses cannot be stalled; busy holds off new requests until done.
// ----------------------------------------------------------------------------
module indexed_list_engine #(
   parameter int Depth     = ile_pkg::DepthDefault,
   parameter int WordWidth = ile_pkg::WordWidthDefault
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic [ile_pkg::ActionWidth-1:0]         req_action,
   input  logic [ile_pkg::IndexWidth-1:0]          req_position,
   input  logic [ile_pkg::IndexWidth-1:0]          req_destination,
   input  logic signed [ile_pkg::OperandWidth-1:0] req_operand,
   output logic                                    rsp_strobe,
   output logic signed [ile_pkg::OperandWidth-1:0] rsp_read_value,
   output logic                                    rsp_has_value,
   output logic                                    rsp_equal_hit,
   output logic [ile_pkg::OutcomeWidth-1:0]        rsp_outcome,
   output logic [ile_pkg::CountWidth-1:0]          rsp_entry_count,
   output logic                                    rsp_last_of_run
);
   import ile_pkg::*;

   ile_cmd_type cmd;
   ile_sts_type sts;

   ile_control u_control (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .sts   (sts)
   );

   ile_datapath #(.Depth(Depth), .WordWidth(WordWidth)) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_action      (req_action),
      .req_position    (req_position),
      .req_destination (req_destination),
      .req_operand     (req_operand),
      .rsp_read_value  (rsp_read_value),
      .rsp_has_value   (rsp_has_value),
      .rsp_equal_hit   (rsp_equal_hit),
      .rsp_outcome     (rsp_outcome),
      .rsp_entry_count (rsp_entry_count),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_strobe      (rsp_strobe)
   );
endmodule

@@ hdl/ile_checker.sv @@
// ----------------------------------------------------------------------------
// ile_checker: port-level checks for the indexed list engine
// Watches request acceptance and response runs over time.
// ----------------------------------------------------------------------------
module ile_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_strobe,
   input logic       rsp_has_value,
   input logic       rsp_equal_hit,
   input logic [1:0] rsp_outcome,
   input logic       rsp_last_of_run
);
   import ile_pkg::*;

   // an accepted transaction makes the block busy next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accept did not raise busy");

   // no response in the cycle right after acceptance
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> !rsp_strobe) else $error("response too early");

   // after a final response the block is idle
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last_of_run |-> !busy) else $error("busy after last");

   // a response carries at most one of value, hit or error
   a_rsp_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $countones({rsp_has_value, rsp_equal_hit,
                                 rsp_outcome != OUT_OK}) <= 1)
      else $error("conflicting response flags");
endmodule

bind indexed_list_engine ile_checker u_ile_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_strobe      (rsp_strobe),
   .rsp_has_value   (rsp_has_value),
   .rsp_equal_hit   (rsp_equal_hit),
   .rsp_outcome     (rsp_outcome),
   .rsp_last_of_run (rsp_last_of_run)
);
